[hdl/trdt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trdt_pkg
// Types and constants shared by the reservation dependency table files.
// ----------------------------------------------------------------------------
package trdt_pkg;

    // table geometry (entry count is a power of two)
    localparam int unsigned TABLE_ENTRIES = 1024;
    localparam int unsigned MAX_PROBES    = 8;
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int unsigned PROBE_W       = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;

    localparam int unsigned KEY_W   = 56;
    localparam int unsigned TABLE_W = 8;
    localparam int unsigned TAG_W   = KEY_W + TABLE_W;
    localparam int unsigned TXN_W   = 32;

    // multiplicative hash constant, split into 32-bit halves
    localparam logic [63:0] HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;
    localparam int unsigned HASH_SHIFT = 29;
    localparam int unsigned SLOT_LSB   = 16;

    typedef enum logic [1:0] {
        KIND_RES_RD = 2'd0,
        KIND_RES_WR = 2'd1,
        KIND_CHK_RD = 2'd2,
        KIND_CHK_WR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_HASH,
        ST_PROBE
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [TXN_W-1:0] rd_min;
        logic [TXN_W-1:0] wr_min;
    } t_entry;

    typedef struct packed {
        logic full;
        logic raw;
        logic war;
        logic waw;
    } t_flags;

endpackage
`default_nettype wire

[hdl/trdt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trdt_in_if / trdt_out_if
// Valid/ready channels for key transactions and dependency results.
// ----------------------------------------------------------------------------
interface trdt_in_if;
    import trdt_pkg::*;

    logic                valid;
    logic                ready;
    t_kind               kind;
    logic [KEY_W-1:0]    key_id;
    logic [TABLE_W-1:0]  table_id;
    logic [TXN_W-1:0]    txn_id;
    logic                last;

    modport source (output valid, kind, key_id, table_id, txn_id, last, input ready);
    modport sink   (input valid, kind, key_id, table_id, txn_id, last, output ready);
endinterface

interface trdt_out_if;
    logic valid;
    logic ready;
    logic waw_dep;
    logic war_dep;
    logic raw_dep;
    logic table_full;

    modport source (output valid, waw_dep, war_dep, raw_dep, table_full, input ready);
    modport sink   (input valid, waw_dep, war_dep, raw_dep, table_full, output ready);
endinterface
`default_nettype wire

[hdl/txn_reservation_dependency_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txn_reservation_dependency_table
// Hashed reservation table with write/read dependency detection per run.
// ----------------------------------------------------------------------------
// Each transaction steps through ST_IDLE (accept), ST_MUL (three 32x32
// partial products registered), ST_HASH (home slot formed and read) and
// ST_PROBE, which checks one slot per read of the entry memory, from the
// home slot along a linear probe window of up to MAX_PROBES slots; a new
// transaction is taken only in ST_IDLE. After reset the block clears all
// TABLE_ENTRIES (1024) entries of the entry memory, one entry per cycle,
// with ready low. A result appears only for a transaction with last set and
// sits in an output register until taken; a new transaction is accepted
// while it waits.
// ----------------------------------------------------------------------------
module txn_reservation_dependency_table (
    input  wire            i_clk,
    input  wire            i_rst_n,
    trdt_in_if.sink        i_item,
    trdt_out_if.source     o_result
);
    import trdt_pkg::*;

    // control state
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_clr_idx, n_clr_idx;
    logic [PROBE_W-1:0]  r_probe, n_probe;
    t_flags              r_flags, n_flags;
    logic                r_out_valid, n_out_valid;

    // payload
    t_kind               r_kind, n_kind;
    logic [TAG_W-1:0]    r_tag, n_tag;
    logic [TXN_W-1:0]    r_txn, n_txn;
    logic                r_last, n_last;
    logic [63:0]         r_p0, n_p0;
    logic [31:0]         r_p1, n_p1;
    logic [31:0]         r_p2, n_p2;
    logic [IDX_W-1:0]    r_slot, n_slot;
    t_flags              r_out, n_out;

    // entry memory
    t_entry              r_mem [TABLE_ENTRIES];
    t_entry              r_rdata;
    logic                w_rd_en;
    logic [IDX_W-1:0]    w_rd_addr;
    logic                w_wr_en;
    logic [IDX_W-1:0]    w_wr_addr;
    t_entry              w_wr_data;

    // hash and probe decode
    logic [63:0]         w_hash;
    logic [63:0]         w_hash_mix;
    logic [IDX_W-1:0]    w_home;
    logic                w_hit;
    logic                w_free;
    logic                w_more;
    logic                w_out_free;
    logic                w_reserve;
    logic [TXN_W-1:0]    w_rd_seen;
    logic [TXN_W-1:0]    w_wr_seen;
    t_entry              w_upd;
    t_flags              w_item_flags;
    t_flags              w_run_flags;

    assign w_hash     = r_p0 + {r_p1 + r_p2, 32'b0};
    assign w_hash_mix = w_hash ^ (w_hash >> HASH_SHIFT);
    assign w_home     = w_hash_mix[SLOT_LSB +: IDX_W];

    assign w_hit      = r_rdata.valid && (r_rdata.tag == r_tag);
    assign w_free     = !r_rdata.valid;
    assign w_more     = !w_hit && !w_free && (r_probe != PROBE_W'(MAX_PROBES - 1));
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_reserve  = (r_kind == KIND_RES_RD) || (r_kind == KIND_RES_WR);

    // a missing key reads as no reader and no writer
    assign w_rd_seen  = w_hit ? r_rdata.rd_min : '0;
    assign w_wr_seen  = w_hit ? r_rdata.wr_min : '0;

    always_comb begin
        if (w_hit) begin
            w_upd = r_rdata;
        end else begin
            w_upd = '{valid: 1'b1, tag: r_tag, rd_min: '0, wr_min: '0};
        end
        if (r_kind == KIND_RES_RD) begin
            if (w_upd.rd_min == '0 || w_upd.rd_min > r_txn) begin
                w_upd.rd_min = r_txn;
            end
        end else begin
            if (w_upd.wr_min == '0 || w_upd.wr_min > r_txn) begin
                w_upd.wr_min = r_txn;
            end
        end

        w_item_flags = '0;
        case (r_kind)
            KIND_RES_RD, KIND_RES_WR: begin
                w_item_flags.full = !w_hit && !w_free;
            end
            KIND_CHK_RD: begin
                w_item_flags.raw = (w_wr_seen != '0) && (w_wr_seen < r_txn);
            end
            default: begin
                w_item_flags.waw = (w_wr_seen != '0) && (w_wr_seen < r_txn);
                w_item_flags.war = (w_rd_seen != '0) && (w_rd_seen < r_txn);
            end
        endcase
        w_run_flags = r_flags | w_item_flags;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_probe     = r_probe;
        n_flags     = r_flags;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_tag       = r_tag;
        n_txn       = r_txn;
        n_last      = r_last;
        n_p0        = r_p0;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_slot      = r_slot;
        n_out       = r_out;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_slot + 1'b1;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_slot;
        w_wr_data   = w_upd;
        i_item.ready = 1'b0;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_idx;
                w_wr_data = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                i_item.ready = 1'b1;
                if (i_item.valid) begin
                    n_kind  = i_item.kind;
                    n_tag   = {i_item.key_id, i_item.table_id};
                    n_txn   = i_item.txn_id;
                    n_last  = i_item.last;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                // low 64 bits of tag * constant from three 32x32 products
                n_p0    = {32'b0, r_tag[31:0]} * {32'b0, HASH_MULT[31:0]};
                n_p1    = r_tag[31:0] * HASH_MULT[63:32];
                n_p2    = r_tag[63:32] * HASH_MULT[31:0];
                n_state = ST_HASH;
            end
            ST_HASH: begin
                n_slot    = w_home;
                n_probe   = '0;
                w_rd_en   = 1'b1;
                w_rd_addr = w_home;
                n_state   = ST_PROBE;
            end
            ST_PROBE: begin
                if (w_more) begin
                    // occupied by another tag: step to the next slot
                    w_rd_en = 1'b1;
                    n_slot  = r_slot + 1'b1;
                    n_probe = r_probe + 1'b1;
                end else if (!r_last || w_out_free) begin
                    w_wr_en = w_reserve && (w_hit || w_free);
                    if (r_last) begin
                        n_out       = w_run_flags;
                        n_out_valid = 1'b1;
                        n_flags     = '0;
                    end else begin
                        n_flags = w_run_flags;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_probe     <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_probe     <= n_probe;
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_tag  <= n_tag;
        r_txn  <= n_txn;
        r_last <= n_last;
        r_p0   <= n_p0;
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_slot <= n_slot;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.waw_dep    = r_out.waw;
    assign o_result.war_dep    = r_out.war;
    assign o_result.raw_dep    = r_out.raw;
    assign o_result.table_full = r_out.full;

endmodule
`default_nettype wire
